[rtl/core/wmcb_pkg.sv]
// ----------------------------------------------------------------------------
// wmcb_pkg
// Shared types, constants and helper functions of the 3x3 max-channel
// color boost filter.
// ----------------------------------------------------------------------------
package wmcb_pkg;

  // frame geometry limits
  localparam int MAX_WIDTH      = 2048;
  localparam int MAX_HEIGHT     = 4096;
  localparam int MIN_DIM        = 3;
  localparam int COL_W          = $clog2(MAX_WIDTH);
  localparam int ROW_W          = $clog2(MAX_HEIGHT);
  localparam int WIDTH_REG_W    = COL_W + 1;
  localparam int HEIGHT_REG_W   = ROW_W + 1;

  // gain format, unsigned Q2.GAIN_FRAC_BITS (boost unsigned Q1.GAIN_FRAC_BITS)
  localparam int GAIN_FRAC_BITS = 8;
  localparam int BOOST_W        = GAIN_FRAC_BITS + 1;
  localparam int GAIN_W         = GAIN_FRAC_BITS + 2;
  localparam int PROD_W         = GAIN_W + 8;

  // configuration port
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = HEIGHT_REG_W;

  // result queue
  localparam int FIFO_DEPTH     = 8;
  localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W     = FIFO_PTR_W + 1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BOOST  = 2'd2
  } reg_idx_t;

  // dominant channel, one-hot
  typedef enum logic [2:0] {
    DOM_RED   = 3'b001,
    DOM_GREEN = 3'b010,
    DOM_BLUE  = 3'b100
  } dom_t;

  typedef struct packed {
    logic [7:0] opacity;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // position of the centre pixel that an item completes
  typedef struct packed {
    logic             emit;
    logic             frame_end;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
  } pos_t;

  typedef struct packed {
    logic [GAIN_W-1:0] high;
    logic [GAIN_W-1:0] low;
  } gains_t;

  typedef struct packed {
    pixel_t           px;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             frame_end;
  } result_t;

  function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

  // multiply, drop the fraction, saturate at 255
  function automatic logic [7:0] scale8(input logic [7:0] v, input logic [GAIN_W-1:0] g);
    logic [PROD_W-1:0] prod;
    logic [GAIN_W-1:0] whole;
    prod  = PROD_W'(v) * PROD_W'(g);
    whole = prod[PROD_W-1:GAIN_FRAC_BITS];
    return (whole > GAIN_W'(255)) ? 8'hFF : whole[7:0];
  endfunction

endpackage

[rtl/core/window_max_color_boost.sv]
// ----------------------------------------------------------------------------
// window_max_color_boost
// 3x3 max-channel color boost filter on a BGRA pixel stream.
// ----------------------------------------------------------------------------
// Throughput: one pixel item per cycle while the output side takes results.
// Once the item holding its lower right neighbor is accepted, the result goes
//   through line store read, window, channel max and scaling into the queue.
// Input is held off when the 8-entry result queue plus items in flight is full.
// Reset (rst_n, synchronous) clears counters, stage valids and the queue and
//   loads width 640, height 480, boost 102; line stores are not cleared.
module window_max_color_boost (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_blue,
  input  logic [7:0]                        in_green,
  input  logic [7:0]                        in_red,
  input  logic [7:0]                        in_opacity,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_blue,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_opacity,
  output logic [wmcb_pkg::ROW_W-1:0]        out_row,
  output logic [wmcb_pkg::COL_W-1:0]        out_column,
  output logic                              out_frame_end,
  input  logic                              cfg_we,
  input  logic [wmcb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wmcb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import wmcb_pkg::*;

  logic                  in_accept;
  pixel_t                px;
  logic [COL_W-1:0]      addr;
  pos_t                  pos;
  gains_t                gains;
  logic                  s1_valid;
  logic                  win_valid;
  pixel_t                win [9];
  pos_t                  win_pos;
  logic                  res_valid;
  result_t               res;
  result_t               rd_data;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W-1:0] occupancy;

  assign px.blue    = in_blue;
  assign px.green   = in_green;
  assign px.red     = in_red;
  assign px.opacity = in_opacity;

  // credit check: every item in flight has a reserved queue slot
  assign occupancy = fifo_count + FIFO_CNT_W'(s1_valid) + FIFO_CNT_W'(win_valid) +
                     FIFO_CNT_W'(res_valid);
  assign in_ready  = (occupancy < FIFO_CNT_W'(FIFO_DEPTH));
  assign in_accept = in_valid && in_ready;

  wmcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_accept (in_accept),
    .addr      (addr),
    .pos       (pos),
    .gains     (gains)
  );

  wmcb_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .px        (px),
    .addr      (addr),
    .pos       (pos),
    .s1_valid  (s1_valid),
    .win_valid (win_valid),
    .win       (win),
    .win_pos   (win_pos)
  );

  wmcb_boost u_boost (
    .clk       (clk),
    .rst_n     (rst_n),
    .win_valid (win_valid),
    .win       (win),
    .win_pos   (win_pos),
    .gains     (gains),
    .res_valid (res_valid),
    .res       (res)
  );

  wmcb_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (res_valid),
    .wr_data   (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rd_data   (rd_data),
    .count     (fifo_count)
  );

  assign out_blue      = rd_data.px.blue;
  assign out_green     = rd_data.px.green;
  assign out_red       = rd_data.px.red;
  assign out_opacity   = rd_data.px.opacity;
  assign out_row       = rd_data.row;
  assign out_column    = rd_data.column;
  assign out_frame_end = rd_data.frame_end;

endmodule

[rtl/core/wmcb_ctrl.sv]
// ----------------------------------------------------------------------------
// wmcb_ctrl
// Configuration registers, raster counters and gain derivation.
// ----------------------------------------------------------------------------
module wmcb_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [wmcb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wmcb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_accept,
  output logic [wmcb_pkg::COL_W-1:0]        addr,
  output wmcb_pkg::pos_t                    pos,
  output wmcb_pkg::gains_t                  gains
);
  import wmcb_pkg::*;

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [BOOST_W-1:0]      boost_r;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;

  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [COL_W-1:0]        c_eff;
  logic [ROW_W-1:0]        r_eff;
  logic [WIDTH_REG_W-1:0]  c_inc;
  logic [HEIGHT_REG_W-1:0] r_inc;
  logic [BOOST_W-1:0]      alpha;

  // clamp geometry to the supported range
  always_comb begin
    if (width_r < WIDTH_REG_W'(MIN_DIM)) begin
      w_eff = WIDTH_REG_W'(MIN_DIM);
    end else if (width_r > WIDTH_REG_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r < HEIGHT_REG_W'(MIN_DIM)) begin
      h_eff = HEIGHT_REG_W'(MIN_DIM);
    end else if (height_r > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // current position, restarting when outside the frame
  always_comb begin
    if ({1'b0, col_r} >= w_eff || {1'b0, row_r} >= h_eff) begin
      c_eff = '0;
      r_eff = '0;
    end else begin
      c_eff = col_r;
      r_eff = row_r;
    end
    c_inc = {1'b0, c_eff} + WIDTH_REG_W'(1);
    r_inc = {1'b0, r_eff} + HEIGHT_REG_W'(1);
    if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_nxt = c_inc[COL_W-1:0];
      row_nxt = r_eff;
    end
  end

  assign addr           = c_eff;
  assign pos.emit       = (r_eff >= ROW_W'(2)) && (c_eff >= COL_W'(2));
  assign pos.frame_end  = ({1'b0, r_eff} == h_eff - HEIGHT_REG_W'(1)) &&
                          ({1'b0, c_eff} == w_eff - WIDTH_REG_W'(1));
  assign pos.row        = r_eff - ROW_W'(1);
  assign pos.column     = c_eff - COL_W'(1);

  // gains, alpha saturates at one
  always_comb begin
    alpha      = (boost_r > BOOST_W'(1 << GAIN_FRAC_BITS)) ?
                 BOOST_W'(1 << GAIN_FRAC_BITS) : boost_r;
    gains.high = GAIN_W'(1 << GAIN_FRAC_BITS) + GAIN_W'(alpha);
    gains.low  = GAIN_W'(1 << GAIN_FRAC_BITS) - GAIN_W'(alpha);
  end

  // registers and counters; a geometry write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_REG_W'(640);
      height_r <= HEIGHT_REG_W'(480);
      boost_r  <= BOOST_W'(102);
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH: begin
          width_r <= cfg_wdata[WIDTH_REG_W-1:0];
          col_r   <= '0;
          row_r   <= '0;
        end
        REG_HEIGHT: begin
          height_r <= cfg_wdata[HEIGHT_REG_W-1:0];
          col_r    <= '0;
          row_r    <= '0;
        end
        REG_BOOST: begin
          boost_r <= cfg_wdata[BOOST_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

[rtl/core/wmcb_window.sv]
// ----------------------------------------------------------------------------
// wmcb_window
// Two line stores and the 3x3 pixel window.
// ----------------------------------------------------------------------------
module wmcb_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_accept,
  input  wmcb_pkg::pixel_t            px,
  input  logic [wmcb_pkg::COL_W-1:0]  addr,
  input  wmcb_pkg::pos_t              pos,
  output logic                        s1_valid,
  output logic                        win_valid,
  output wmcb_pkg::pixel_t            win [9],
  output wmcb_pkg::pos_t              win_pos
);
  import wmcb_pkg::*;

  pixel_t           upper_line_r  [MAX_WIDTH];
  pixel_t           middle_line_r [MAX_WIDTH];
  pixel_t           up_rd_r, mid_rd_r, px_r;
  logic [COL_W-1:0] addr_r;
  pos_t             pos_r;
  logic             s1_valid_r;

  pixel_t           win_r   [9];
  pixel_t           win_nxt [9];
  pos_t             win_pos_r;
  logic             win_valid_r;

  // line stores: read both at accept, middle written at once, upper from the registered middle read
  always_ff @(posedge clk) begin
    if (in_accept) begin
      middle_line_r[addr] <= px;
      up_rd_r             <= upper_line_r[addr];
      mid_rd_r            <= middle_line_r[addr];
      px_r                <= px;
      addr_r              <= addr;
      pos_r               <= pos;
    end
    if (s1_valid_r) begin
      upper_line_r[addr_r] <= mid_rd_r;
    end
  end

  // window shift, new column enters on the right
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3+0] = win_r[i*3+1];
      win_nxt[i*3+1] = win_r[i*3+2];
    end
    win_nxt[2] = up_rd_r;
    win_nxt[5] = mid_rd_r;
    win_nxt[8] = px_r;
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      win_r     <= win_nxt;
      win_pos_r <= pos_r;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      win_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_accept;
      win_valid_r <= s1_valid_r && pos_r.emit;
    end
  end

  assign s1_valid  = s1_valid_r;
  assign win_valid = win_valid_r;
  assign win       = win_r;
  assign win_pos   = win_pos_r;

endmodule

[rtl/core/wmcb_boost.sv]
// ----------------------------------------------------------------------------
// wmcb_boost
// Channel maxima over the window, dominant channel pick and gain scaling.
// ----------------------------------------------------------------------------
module wmcb_boost (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               win_valid,
  input  wmcb_pkg::pixel_t   win [9],
  input  wmcb_pkg::pos_t     win_pos,
  input  wmcb_pkg::gains_t   gains,
  output logic               res_valid,
  output wmcb_pkg::result_t  res
);
  import wmcb_pkg::*;

  logic [7:0] max_r, max_g, max_b;
  dom_t       dom;
  dom_t       dom_r;
  pixel_t     ctr_r;
  pos_t       pos_r;
  logic       valid_r;
  logic [GAIN_W-1:0] g_red, g_green, g_blue;

  // channel maxima over the nine neighbors
  always_comb begin
    max_r = '0;
    max_g = '0;
    max_b = '0;
    for (int i = 0; i < 9; i++) begin
      max_r = max8(max_r, win[i].red);
      max_g = max8(max_g, win[i].green);
      max_b = max8(max_b, win[i].blue);
    end
    if (max_r >= max_g && max_r >= max_b) begin
      dom = DOM_RED;
    end else if (max_g >= max_b) begin
      dom = DOM_GREEN;
    end else begin
      dom = DOM_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (win_valid) begin
      dom_r <= dom;
      ctr_r <= win[4];
      pos_r <= win_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= win_valid;
    end
  end

  // per-channel gain select
  always_comb begin
    g_red   = gains.low;
    g_green = gains.low;
    g_blue  = gains.low;
    case (dom_r)
      DOM_RED:   g_red   = gains.high;
      DOM_GREEN: g_green = gains.high;
      DOM_BLUE:  g_blue  = gains.high;
      default:   g_red   = gains.high;
    endcase
  end

  // scaled result, registered by the result queue
  assign res_valid         = valid_r;
  assign res.px.opacity    = ctr_r.opacity;
  assign res.px.red        = scale8(ctr_r.red, g_red);
  assign res.px.green      = scale8(ctr_r.green, g_green);
  assign res.px.blue       = scale8(ctr_r.blue, g_blue);
  assign res.row           = pos_r.row;
  assign res.column        = pos_r.column;
  assign res.frame_end     = pos_r.frame_end;

endmodule

[rtl/core/wmcb_out_fifo.sv]
// ----------------------------------------------------------------------------
// wmcb_out_fifo
// Result queue that decouples the pipeline from output backpressure.
// ----------------------------------------------------------------------------
module wmcb_out_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  wmcb_pkg::result_t                 wr_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output wmcb_pkg::result_t                 rd_data,
  output logic [wmcb_pkg::FIFO_CNT_W-1:0]   count
);
  import wmcb_pkg::*;

  result_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic                  pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign rd_data   = fifo_r[rd_ptr_r];
  assign count     = count_r;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      if (wr_en && !pop) begin
        count_r <= count_r + FIFO_CNT_W'(1);
      end else if (!wr_en && pop) begin
        count_r <= count_r - FIFO_CNT_W'(1);
      end
    end
  end

  // the input credit check must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (count_r != FIFO_CNT_W'(FIFO_DEPTH) || pop))
    else $error("result queue overflow");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !pop) |=> (count_r == $past(count_r) + FIFO_CNT_W'(1)))
    else $error("fill count did not follow a write");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (!wr_en && pop) |=> (count_r == $past(count_r) - FIFO_CNT_W'(1)))
    else $error("fill count did not follow a read");

endmodule

[verif/color_boost_checker.sv]
// ----------------------------------------------------------------------------
// color_boost_checker
// Watches the pixel, result and register ports of the 3x3 max-channel color
// boost filter. Keeps its own line stores, window and frame counters, works
// out the filtered pixel for each accepted item that completes a window and
// compares each leaving result, field by field, with the oldest one it is owed.
// ----------------------------------------------------------------------------
module color_boost_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [7:0]                      in_blue,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_opacity,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [7:0]                      out_blue,
  input  logic [7:0]                      out_green,
  input  logic [7:0]                      out_red,
  input  logic [7:0]                      out_opacity,
  input  logic [wmcb_pkg::ROW_W-1:0]      out_row,
  input  logic [wmcb_pkg::COL_W-1:0]      out_column,
  input  logic                            out_frame_end,
  input  logic                            cfg_we,
  input  logic [wmcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wmcb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              n_pending,
  output int                              n_checked,
  output int                              n_failed
);
  import wmcb_pkg::*;

  localparam int GAIN_ONE        = 1 << GAIN_FRAC_BITS;
  localparam int WIDTH_AT_RESET  = 640;
  localparam int HEIGHT_AT_RESET = 480;
  localparam int BOOST_AT_RESET  = 102;

  // register copies and filter state
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [BOOST_W-1:0]      boost_reg;
  pixel_t                  upper_row [MAX_WIDTH];
  pixel_t                  middle_row [MAX_WIDTH];
  pixel_t                  win [9];
  int unsigned             col_pos;
  int unsigned             row_pos;
  result_t                 boosted_due [$];

  initial begin
    width_reg  = WIDTH_REG_W'(WIDTH_AT_RESET);
    height_reg = HEIGHT_REG_W'(HEIGHT_AT_RESET);
    boost_reg  = BOOST_W'(BOOST_AT_RESET);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    col_pos   = 0;
    row_pos   = 0;
    n_pending = 0;
    n_checked = 0;
    n_failed  = 0;
  end

  // channel times gain, fraction dropped, clipped at 255
  function automatic logic [7:0] boost_channel(input logic [7:0] v,
                                               input logic [GAIN_W-1:0] g);
    logic [PROD_W-1:0] full;
    full = PROD_W'(v) * PROD_W'(g);
    full = full >> GAIN_FRAC_BITS;
    if (full > PROD_W'(255)) return 8'hFF;
    return full[7:0];
  endfunction

  // register write; a geometry write restarts the frame
  function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_WIDTH: begin
        width_reg = data[WIDTH_REG_W-1:0];
        col_pos   = 0;
        row_pos   = 0;
      end
      REG_HEIGHT: begin
        height_reg = data[HEIGHT_REG_W-1:0];
        col_pos    = 0;
        row_pos    = 0;
      end
      REG_BOOST: boost_reg = data[BOOST_W-1:0];
      default: ;
    endcase
  endfunction

  // one pixel in: shift line stores and window, owe a result for interior centres
  function automatic void filter_pixel(input pixel_t px);
    int unsigned       w, h, c, r, alpha;
    pixel_t            up, mid, ctr;
    logic [7:0]        top_r, top_g, top_b;
    logic [GAIN_W-1:0] g_hi, g_lo, g_red, g_green, g_blue;
    dom_t              lead;
    result_t           res;

    w = (width_reg < MIN_DIM) ? MIN_DIM : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg < MIN_DIM) ? MIN_DIM : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    c = col_pos;
    r = row_pos;
    if (c >= w || r >= h) begin
      c = 0;
      r = 0;
    end

    up            = upper_row[c];
    mid           = middle_row[c];
    upper_row[c]  = mid;
    middle_row[c] = px;
    for (int i = 0; i < 3; i++) begin
      win[3*i]   = win[3*i+1];
      win[3*i+1] = win[3*i+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = px;

    if (r >= 2 && c >= 2) begin
      top_r = '0;
      top_g = '0;
      top_b = '0;
      for (int i = 0; i < 9; i++) begin
        if (win[i].red > top_r) top_r = win[i].red;
        if (win[i].green > top_g) top_g = win[i].green;
        if (win[i].blue > top_b) top_b = win[i].blue;
      end
      // ties go to red, then green
      if (top_r >= top_g && top_r >= top_b) lead = DOM_RED;
      else if (top_g >= top_b) lead = DOM_GREEN;
      else lead = DOM_BLUE;

      alpha   = (boost_reg > GAIN_ONE) ? GAIN_ONE : boost_reg;
      g_hi    = GAIN_W'(GAIN_ONE + alpha);
      g_lo    = GAIN_W'(GAIN_ONE - alpha);
      g_red   = (lead == DOM_RED) ? g_hi : g_lo;
      g_green = (lead == DOM_GREEN) ? g_hi : g_lo;
      g_blue  = (lead == DOM_BLUE) ? g_hi : g_lo;

      ctr              = win[4];
      res.px.blue      = boost_channel(ctr.blue, g_blue);
      res.px.green     = boost_channel(ctr.green, g_green);
      res.px.red       = boost_channel(ctr.red, g_red);
      res.px.opacity   = ctr.opacity;
      res.row          = ROW_W'(r - 1);
      res.column       = COL_W'(c - 1);
      res.frame_end    = (r == h - 1) && (c == w - 1);
      boosted_due.push_back(res);
    end

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_failed++;
    end
  endfunction

  // everything is sampled at the edge where the block samples it
  always @(posedge clk) begin : watch
    result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (boosted_due.size() == 0) begin
          $display("%0t: result with nothing owed, row %0d column %0d", $time,
                   out_row, out_column);
          n_failed++;
        end else begin
          want = boosted_due.pop_front();
          check_field("blue", 16'(want.px.blue), 16'(out_blue));
          check_field("green", 16'(want.px.green), 16'(out_green));
          check_field("red", 16'(want.px.red), 16'(out_red));
          check_field("opacity", 16'(want.px.opacity), 16'(out_opacity));
          check_field("row", 16'(want.row), 16'(out_row));
          check_field("column", 16'(want.column), 16'(out_column));
          check_field("frame_end", 16'(want.frame_end), 16'(out_frame_end));
          n_checked++;
        end
      end
      if (cfg_we) write_register(cfg_index, cfg_wdata);
      if (in_valid && in_ready) filter_pixel({in_opacity, in_red, in_green, in_blue});
      n_pending = boosted_due.size();
    end
  end

endmodule

[verif/window_max_color_boost_tb.sv]
// ----------------------------------------------------------------------------
// window_max_color_boost_tb
// Drives pixel frames of many geometries and boost settings through the
// filter, starting with a few hand-made 3x3 frames and then random frames
// with random idling on both sides and one long output stall. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module window_max_color_boost_tb;
  import wmcb_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_ITEMS = 1850;
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES  = 40;
  localparam int LONG_STALL   = 150;
  localparam int LIMIT_CYCLES = 300000;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int {
    TINT_NONE,
    TINT_LOW_RED,
    TINT_LOW_RED_GREEN,
    TINT_LOW_GREEN
  } tint_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [7:0]              in_blue = 8'd0, in_green = 8'd0, in_red = 8'd0, in_opacity = 8'd0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [7:0]              out_blue, out_green, out_red, out_opacity;
  logic [ROW_W-1:0]        out_row;
  logic [COL_W-1:0]        out_column;
  logic                    out_frame_end;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  int n_pending, n_checked, n_failed;
  int send_idle_pct = 21;
  int recv_idle_pct = 49;
  int items_sent = 0;
  int settings_written = 0;
  bit squeeze_armed = 1'b0;

  window_max_color_boost DUT (.*);

  color_boost_checker checker_i (.*);

  initial forever #(CLK_PERIOD / 2) clk = ~clk;

  // watchdog
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int stall_cnt;
    forever begin
      @(posedge clk);
      if (squeeze_armed) begin
        squeeze_armed = 1'b0;
        out_ready <= 1'b0;
        for (stall_cnt = 0; stall_cnt < LONG_STALL; stall_cnt++) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // random pixel; some all-grey or all-extreme, tint holds one or two channels back
  function automatic pixel_t random_pixel(input tint_t tint);
    pixel_t p;
    p = $urandom;
    case ($urandom_range(5))
      0: begin
        p.green = p.red;
        p.blue  = p.red;
      end
      1: begin
        p.red   = {8{p.red[0]}};
        p.green = {8{p.green[0]}};
        p.blue  = {8{p.blue[0]}};
      end
      default: ;
    endcase
    case (tint)
      TINT_LOW_RED: p.red = p.red >> 2;
      TINT_LOW_RED_GREEN: begin
        p.red   = p.red >> 2;
        p.green = p.green >> 2;
      end
      TINT_LOW_GREEN: p.green = p.green >> 2;
      default: ;
    endcase
    return p;
  endfunction

  // offer one item; valid stays up from one item to the next unless a gap is drawn
  task automatic offer_pixel(input pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_opacity, in_red, in_green, in_blue} <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // wait until every owed result is out, then let border items drain
  task automatic wait_idle();
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register writes back to back; unused high bits of the data carry noise
  task automatic load_settings(input bit geom, input logic [WIDTH_REG_W-1:0] w,
                               input logic [HEIGHT_REG_W-1:0] h,
                               input logic [BOOST_W-1:0] b, input bit spare);
    logic [CFG_DATA_W-1:0] word;
    cfg_we <= 1'b1;
    if (geom) begin
      word = CFG_DATA_W'($urandom);
      word[WIDTH_REG_W-1:0] = w;
      cfg_index <= REG_WIDTH;
      cfg_wdata <= word;
      @(posedge clk);
      cfg_index <= REG_HEIGHT;
      cfg_wdata <= h;
      @(posedge clk);
    end
    word = CFG_DATA_W'($urandom);
    word[BOOST_W-1:0] = b;
    cfg_index <= REG_BOOST;
    cfg_wdata <= word;
    @(posedge clk);
    if (spare) begin
      cfg_index <= REG_SPARE;
      cfg_wdata <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  initial begin : stimulus
    int                      phase, count, frame, w_eff, h_eff, rand_sent;
    logic [WIDTH_REG_W-1:0]  w;
    logic [HEIGHT_REG_W-1:0] h;
    logic [BOOST_W-1:0]      b;
    bit                      geom;
    tint_t                   tint;
    pixel_t                  shade [3];

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hand-made 3x3 frames, geometry below minimum, boost past full scale
    shade[0] = 32'hFF_FF_FF_FF;  // every channel equal and saturating, red takes the tie
    shade[1] = 32'h00_00_C8_C8;  // green ties blue, green takes it
    shade[2] = 32'h80_0A_14_FF;  // blue leads
    load_settings(1'b1, '0, HEIGHT_REG_W'(1), '1, 1'b0);
    for (int f = 0; f < 2; f++) repeat (9) offer_pixel(shade[f]);
    in_valid <= 1'b0;
    wait_idle();
    // no boost at all
    load_settings(1'b0, '0, '0, '0, 1'b0);
    repeat (9) offer_pixel(shade[2]);
    in_valid <= 1'b0;
    wait_idle();

    // random frames
    w_eff     = MIN_DIM;
    h_eff     = MIN_DIM;
    rand_sent = 0;
    for (phase = 0; rand_sent < RANDOM_ITEMS; phase++) begin
      // idling pattern by thirds of the random items
      if (rand_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 49;
      end else if (rand_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      tint = tint_t'($urandom_range(3));
      geom = ($urandom_range(4) != 0) || (phase < 8);
      w = WIDTH_REG_W'($urandom_range(3, 12));
      h = HEIGHT_REG_W'($urandom_range(3, 8));
      if ($urandom_range(9) == 0) w = WIDTH_REG_W'($urandom_range(2));
      else if ($urandom_range(9) == 0) w = WIDTH_REG_W'($urandom_range(13, 40));
      if ($urandom_range(9) == 0) h = HEIGHT_REG_W'($urandom_range(2));
      case ($urandom_range(9))
        0: b = '0;
        1: b = BOOST_W'(256);
        2: b = BOOST_W'($urandom_range(257, 511));
        default: b = BOOST_W'($urandom_range(1, 255));
      endcase
      // width and height past their limits, and a small frame for the long stall
      if (phase == 2) begin
        w = '1;
        h = HEIGHT_REG_W'(3);
      end else if (phase == 4) begin
        w = WIDTH_REG_W'(3);
        h = '1;
      end else if (phase == 7) begin
        w = WIDTH_REG_W'(4);
        h = HEIGHT_REG_W'(4);
      end

      load_settings(geom, w, h, b, $urandom_range(6) == 0);
      if (geom) begin
        w_eff = (w < MIN_DIM) ? MIN_DIM : (w > MAX_WIDTH) ? MAX_WIDTH : w;
        h_eff = (h < MIN_DIM) ? MIN_DIM : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
      end
      frame = w_eff * h_eff;

      if (phase == 2) count = 120;
      else if (phase == 4) count = 90;
      else if (phase == 7) count = 200;
      else if ($urandom_range(9) < 6) count = frame * $urandom_range(1, 2);
      else count = $urandom_range(1, 2 * frame);
      if (phase != 2 && count > 150 && phase != 7) count = 150;

      if (phase == 7) squeeze_armed = 1'b1;
      repeat (count) offer_pixel(random_pixel(tint));
      in_valid <= 1'b0;
      rand_sent += count;
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d pixel items under %0d register settings, %0d results compared",
             items_sent, settings_written, n_checked);
    $display("geometry 3x3 to 40 wide, widths and heights past their limits, boost 0 to past full");
    if (n_failed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/wmcb_pkg.sv
rtl/core/wmcb_ctrl.sv
rtl/core/wmcb_window.sv
rtl/core/wmcb_boost.sv
rtl/core/wmcb_out_fifo.sv
rtl/core/window_max_color_boost.sv
verif/color_boost_checker.sv
verif/window_max_color_boost_tb.sv
